// ===== design/fwg_pkg.sv =====
// Shared types and constants for the FIR filter with output gain.
package fwg_pkg;

  // Transaction modes on the input channel
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int CIDX_W    = 4;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int OUT_SHIFT = 23;

  localparam logic signed [GAIN_W-1:0]   GAIN_RESET = 16'sd256;
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX    = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN    = 24'sh800000;

  // Control from the sequencer to the sample and tap store
  typedef struct packed {
    logic smp_wr;  // write one sample
    logic tap_wr;  // write one coefficient
    logic clr;     // empty the delay line
    logic rd;      // read one sample and one coefficient
  } store_ctl_t;

endpackage

// ===== design/fir_filter_with_gain.sv =====
// Top level: sequencer, shared multiply-accumulate, gain, rounding and output register.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  mode, sample, coef_index, coef_value
//  output    out        out_valid / out_stall filtered, saturated
//  config    in         cfg_we               cfg_wdata (gain, Q8.8)
//
// A sample transaction runs from acceptance through the MAC, drain, gain and round states to a loaded result;
// the shared MAC reads one tap and one delay-line entry from memory per cycle.
// Coefficient, clear and unused-mode transactions give no result and leave the sequencer idle.
// Reset is synchronous; it empties the delay line and tap table via valid bits at once.
// The output register lets the next transaction enter while a result waits under stall;
// a new result waits in the final stage until the output register frees up.
module fir_filter_with_gain #(
  parameter int TAPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic signed [fwg_pkg::SAMPLE_W-1:0] sample,
  input  logic [fwg_pkg::CIDX_W-1:0]          coef_index,
  input  logic signed [fwg_pkg::COEF_W-1:0]   coef_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fwg_pkg::SAMPLE_W-1:0] filtered,
  output logic                                saturated,
  input  logic                                cfg_we,
  input  logic signed [fwg_pkg::GAIN_W-1:0]   cfg_wdata
);

  localparam int AW    = $clog2(TAPS);
  localparam int EW    = (AW > fwg_pkg::CIDX_W) ? AW : fwg_pkg::CIDX_W;
  localparam int ACC_W = fwg_pkg::PROD_W + AW;
  localparam int SC_W  = ACC_W + fwg_pkg::GAIN_W;
  localparam int Q_W   = SC_W - fwg_pkg::OUT_SHIFT;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
  localparam logic signed [SC_W-1:0] RND_BIAS =
    SC_W'((64'd1 << fwg_pkg::OUT_SHIFT) - 64'd1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_DRAIN = 6'b000100,
    S_GAIN  = 6'b001000,
    S_ROUND = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                              state;
  logic signed [fwg_pkg::GAIN_W-1:0]   gain;
  logic [AW-1:0]                       widx;
  logic [AW-1:0]                       widx_next;
  logic [AW-1:0]                       k;
  logic [AW-1:0]                       pos;
  logic                                rd_v;
  logic                                prod_v;
  logic signed [fwg_pkg::PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]             acc;
  logic signed [SC_W-1:0]              scaled;
  logic signed [SC_W-1:0]              biased;
  logic signed [Q_W-1:0]               q;
  logic                                q_fits;
  logic                                in_fire;
  logic                                out_load;
  logic [EW-1:0]                       cidx_ext;
  logic                                cidx_hit;
  fwg_pkg::store_ctl_t                 sctl;
  logic signed [fwg_pkg::SAMPLE_W-1:0] rd_smp;
  logic signed [fwg_pkg::COEF_W-1:0]   rd_tap;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);
  assign widx_next = (widx == LAST) ? '0 : widx + 1'b1;
  assign cidx_ext  = EW'(coef_index);
  assign cidx_hit  = (32'(cidx_ext) < TAPS);

  // Store control decoded from the accepted transaction and the MAC phase
  always_comb begin
    sctl.smp_wr = in_fire && (mode == fwg_pkg::MODE_SAMPLE);
    sctl.tap_wr = in_fire && (mode == fwg_pkg::MODE_COEF) && cidx_hit;
    sctl.clr    = in_fire && (mode == fwg_pkg::MODE_CLEAR);
    sctl.rd     = (state == S_MAC);
  end

  fwg_store #(
    .TAPS (TAPS),
    .AW   (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .smp_waddr (widx_next),
    .smp_wdata (sample),
    .tap_waddr (cidx_ext[AW-1:0]),
    .tap_wdata (coef_value),
    .smp_raddr (pos),
    .tap_raddr (k),
    .rd_smp    (rd_smp),
    .rd_tap    (rd_tap)
  );

  // Gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= fwg_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_wdata;
    end
  end

  // Sequencer and write index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      widx  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (mode)
              fwg_pkg::MODE_SAMPLE: begin
                widx  <= widx_next;
                state <= S_MAC;
              end
              fwg_pkg::MODE_CLEAR: begin
                widx <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_MAC: begin
          if (k == LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !prod_v) begin
            state <= S_GAIN;
          end
        end
        S_GAIN:  state <= S_ROUND;
        S_ROUND: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Tap counter and delay-line read pointer, walking back from the newest sample
  always_ff @(posedge clk) begin
    if (in_fire) begin
      k   <= '0;
      pos <= widx_next;
    end else if (state == S_MAC) begin
      k   <= k + 1'b1;
      pos <= (pos == '0) ? LAST : pos - 1'b1;
    end
  end

  // MAC pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= (state == S_MAC);
      prod_v <= rd_v;
    end
  end

  // Multiply, accumulate, then scale by gain
  always_ff @(posedge clk) begin
    prod <= rd_smp * rd_tap;
    if (in_fire) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == S_GAIN) begin
      scaled <= SC_W'(acc) * SC_W'(gain);
    end
    if (state == S_ROUND) begin
      q <= biased[SC_W-1:fwg_pkg::OUT_SHIFT];
    end
  end

  // Truncate toward zero: bias negative values before the arithmetic shift
  assign biased = scaled + (scaled[SC_W-1] ? RND_BIAS : '0);
  assign q_fits = (&q[Q_W-1:fwg_pkg::SAMPLE_W-1]) || !(|q[Q_W-1:fwg_pkg::SAMPLE_W-1]);

  // Output register: clamp and hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      saturated <= !q_fits;
      if (q_fits) begin
        filtered <= q[fwg_pkg::SAMPLE_W-1:0];
      end else begin
        filtered <= q[Q_W-1] ? fwg_pkg::OUT_MIN : fwg_pkg::OUT_MAX;
      end
    end
  end

  // A sample transaction starts the MAC at the first tap
  a_mac_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode == fwg_pkg::MODE_SAMPLE) |=> (state == S_MAC && k == '0))
    else $error("MAC did not start at tap zero");

  // Gain stage sees a fully drained MAC pipeline
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_GAIN) |-> (!rd_v && !prod_v))
    else $error("gain stage entered with MAC pipeline busy");

  // A finished result waits while the output register is full and stalled
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("result left final stage while output was blocked");

  // A saturated result is clamped to a range limit
  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (filtered == fwg_pkg::OUT_MAX || filtered == fwg_pkg::OUT_MIN))
    else $error("saturated result not at a range limit");

endmodule

// ===== design/fwg_store.sv =====
// Delay line and tap table memories with per-entry valid bits and registered reads.
module fwg_store #(
  parameter int TAPS = 16,
  parameter int AW   = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fwg_pkg::store_ctl_t                  ctl,
  input  logic [AW-1:0]                        smp_waddr,
  input  logic signed [fwg_pkg::SAMPLE_W-1:0]  smp_wdata,
  input  logic [AW-1:0]                        tap_waddr,
  input  logic signed [fwg_pkg::COEF_W-1:0]    tap_wdata,
  input  logic [AW-1:0]                        smp_raddr,
  input  logic [AW-1:0]                        tap_raddr,
  output logic signed [fwg_pkg::SAMPLE_W-1:0]  rd_smp,
  output logic signed [fwg_pkg::COEF_W-1:0]    rd_tap
);

  logic signed [fwg_pkg::SAMPLE_W-1:0] smp_mem [TAPS];
  logic signed [fwg_pkg::COEF_W-1:0]   tap_mem [TAPS];
  logic [TAPS-1:0]                     smp_valid;
  logic [TAPS-1:0]                     tap_valid;

  logic signed [fwg_pkg::SAMPLE_W-1:0] smp_q;
  logic signed [fwg_pkg::COEF_W-1:0]   tap_q;
  logic                                smp_q_valid;
  logic                                tap_q_valid;

  // Sample memory: write port and registered read port
  always_ff @(posedge clk) begin
    if (ctl.smp_wr) begin
      smp_mem[smp_waddr] <= smp_wdata;
    end
    if (ctl.rd) begin
      smp_q <= smp_mem[smp_raddr];
    end
  end

  // Tap memory: write port and registered read port
  always_ff @(posedge clk) begin
    if (ctl.tap_wr) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    if (ctl.rd) begin
      tap_q <= tap_mem[tap_raddr];
    end
  end

  // Valid bits: a sample never written since reset or clear, or a tap never written since reset, reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid   <= '0;
      tap_valid   <= '0;
      smp_q_valid <= 1'b0;
      tap_q_valid <= 1'b0;
    end else begin
      if (ctl.clr) begin
        smp_valid <= '0;
      end else if (ctl.smp_wr) begin
        smp_valid[smp_waddr] <= 1'b1;
      end
      if (ctl.tap_wr) begin
        tap_valid[tap_waddr] <= 1'b1;
      end
      if (ctl.rd) begin
        smp_q_valid <= smp_valid[smp_raddr];
        tap_q_valid <= tap_valid[tap_raddr];
      end
    end
  end

  assign rd_smp = smp_q_valid ? smp_q : '0;
  assign rd_tap = tap_q_valid ? tap_q : '0;

endmodule
